>>> rtl/ndd_pkg.sv
// Shared types, constants and helpers for the nearest-neighbor downscaler.
// No dependencies; imported by every module of the block.
package ndd_pkg;

  localparam int DimW    = 8;              // size register width
  localparam int CoordW  = 7;              // column / row coordinate width
  localparam int CntW    = 8;              // destination counters, can reach MaxDim
  localparam int ColorW  = 8;
  localparam int ProdW   = CntW + DimW;    // d * src before the divide
  localparam int MaxDim  = 128;
  localparam int CfgIdxW = 2;
  localparam int DivCntW = $clog2(CoordW);

  localparam logic [DimW-1:0] ResetDim = DimW'(96);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_TGT_WIDTH  = 2'd2,
    CFG_TGT_HEIGHT = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_DIV_START,
    ST_DIV_WAIT
  } ctrl_state_e;

  typedef struct packed {
    logic load;       // capture the accepted pixel
    logic step;       // advance counters, emit the pixel if it is sampled
    logic div_start;  // launch the sample-position divide
    logic wb;         // write the quotient into the wanted position
  } dp_cmd_t;

  typedef struct packed {
    logic hit;        // held pixel is a sample point
    logic out_busy;   // output register full and stalled
    logic need_div;   // step moves a sampling position
    logic div_done;
  } dp_sts_t;

  // Zero reads as one, anything above MaxDim as MaxDim.
  function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > DimW'(MaxDim)) begin
      r = DimW'(MaxDim);
    end
    return r;
  endfunction

endpackage

>>> rtl/nearest_neighbour_downscaler_top.sv
// Top level of the nearest-neighbor downscaler: ports, config handshake, FSM + datapath.
// Depends on ndd_pkg, ndd_ctrl, ndd_dp (which holds ndd_div).
//
// Takes RGB source pixels in raster order, one beat per pixel, and forwards only the pixel
// at source position (floor(dx*sw/dw), floor(dy*sh/dh)) for each destination pixel, tagged
// with its destination column and row; frame_end marks the last destination pixel. The
// target size is clamped to the source size (never upscales); sizes of zero read as one and
// sizes above 128 as 128. frame_start on a pixel clears all position counters before that
// pixel is handled; without it the counters wrap at the end of each row and frame. Size
// registers are written through the cfg port (index 0 source width, 1 source height,
// 2 target width, 3 target height, reset 96 each); write them only while no pixel is in
// flight, new values apply from the next pixel. Pixel flow: a pixel is accepted, then the
// counter step runs; when that step moves a sampling position, a 7-iteration shift-subtract
// divider (one quotient bit per cycle) is then started to compute the next wanted source
// column or row, and the next pixel is accepted once the quotient is written.
// A sampled pixel also waits in the step while the output register holds an earlier result
// that is stalled; a pixel that is not sampled never waits on the output side.
module nearest_neighbour_downscaler_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // pixel input
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ndd_pkg::ColorW-1:0]  red_in_i,
  input  logic [ndd_pkg::ColorW-1:0]  green_in_i,
  input  logic [ndd_pkg::ColorW-1:0]  blue_in_i,
  input  logic                        frame_start_i,
  // pixel output
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ndd_pkg::ColorW-1:0]  red_out_o,
  output logic [ndd_pkg::ColorW-1:0]  green_out_o,
  output logic [ndd_pkg::ColorW-1:0]  blue_out_o,
  output logic [ndd_pkg::CoordW-1:0]  out_column_o,
  output logic [ndd_pkg::CoordW-1:0]  out_row_o,
  output logic                        frame_end_o,
  // register writes
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ndd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [ndd_pkg::DimW-1:0]    cfg_data_i
);
  import ndd_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    cfg_we;

  // registers are plain flops, a write beat always lands
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  ndd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ndd_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .red_in_i      (red_in_i),
    .green_in_i    (green_in_i),
    .blue_in_i     (blue_in_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .red_out_o     (red_out_o),
    .green_out_o   (green_out_o),
    .blue_out_o    (blue_out_o),
    .out_column_o  (out_column_o),
    .out_row_o     (out_row_o),
    .frame_end_o   (frame_end_o)
  );

endmodule

>>> rtl/ndd_div.sv
// Iterative shift-subtract divider, one quotient bit per cycle.
// Depends on ndd_pkg. Quotient must fit in CoordW bits (dividend < divisor << CoordW).
module ndd_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ndd_pkg::ProdW-1:0] dividend_i,
  input  logic [ndd_pkg::DimW-1:0]  divisor_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [ndd_pkg::CoordW-1:0] quotient_o
);
  import ndd_pkg::*;

  logic               run_q, run_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [ProdW-1:0]   rem_q, rem_d;
  logic [ProdW-1:0]   dsr_q, dsr_d;
  logic [CoordW-1:0]  quo_q, quo_d;
  logic               ge;

  assign ge = rem_q >= dsr_q;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = DivCntW'(CoordW - 1);
      rem_d = dividend_i;
      dsr_d = ProdW'(divisor_i) << (CoordW - 1);
    end else if (run_q) begin
      rem_d = ge ? rem_q - dsr_q : rem_q;
      quo_d = {quo_q[CoordW-2:0], ge};
      dsr_d = dsr_q >> 1;
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - DivCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign busy_o     = run_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> rtl/ndd_dp.sv
// Datapath: size registers, position counters, sample-position divide, output register.
// Depends on ndd_pkg and ndd_div; driven by ndd_ctrl through dp_cmd_t.
module ndd_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ndd_pkg::dp_cmd_t              cmd_i,
  output ndd_pkg::dp_sts_t              sts_o,
  input  logic                          cfg_we_i,
  input  logic [ndd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ndd_pkg::DimW-1:0]      cfg_data_i,
  input  logic [ndd_pkg::ColorW-1:0]    red_in_i,
  input  logic [ndd_pkg::ColorW-1:0]    green_in_i,
  input  logic [ndd_pkg::ColorW-1:0]    blue_in_i,
  input  logic                          frame_start_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ndd_pkg::ColorW-1:0]    red_out_o,
  output logic [ndd_pkg::ColorW-1:0]    green_out_o,
  output logic [ndd_pkg::ColorW-1:0]    blue_out_o,
  output logic [ndd_pkg::CoordW-1:0]    out_column_o,
  output logic [ndd_pkg::CoordW-1:0]    out_row_o,
  output logic                          frame_end_o
);
  import ndd_pkg::*;

  // size registers
  logic [DimW-1:0] src_w_q, src_h_q, tgt_w_q, tgt_h_q;
  logic [DimW-1:0] sw, sh, tw_raw, th_raw, tw, th;

  // held pixel
  logic [ColorW-1:0] red_q, green_q, blue_q;
  logic              fs_q;

  // position state
  logic [CoordW-1:0] sc_q, sc_d, sr_q, sr_d, wc_q, wc_d, wr_q, wr_d;
  logic [CntW-1:0]   dc_q, dc_d, dr_q, dr_d;
  logic [CoordW-1:0] sc, sr, wc, wr;
  logic [CntW-1:0]   dc, dr, dc1, dr1;
  logic [DimW-1:0]   sc1, sr1;
  logic              hit, row_end, row_used, row_wrap, col_div, row_div;

  // divide operands
  logic [CntW-1:0]   div_d_q;
  logic [DimW-1:0]   div_src_q, div_dst_q;
  logic              div_row_q;
  logic [ProdW-1:0]  prod;
  logic              div_busy, div_done;
  logic [CoordW-1:0] div_quo;

  // output register
  logic              out_valid_q;
  logic              out_load, out_busy;
  logic [ColorW-1:0] out_red_q, out_green_q, out_blue_q;
  logic [CoordW-1:0] out_col_q, out_row_q;
  logic              out_fe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= ResetDim;
      src_h_q <= ResetDim;
      tgt_w_q <= ResetDim;
      tgt_h_q <= ResetDim;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_SRC_WIDTH:  src_w_q <= cfg_data_i;
        CFG_SRC_HEIGHT: src_h_q <= cfg_data_i;
        CFG_TGT_WIDTH:  tgt_w_q <= cfg_data_i;
        CFG_TGT_HEIGHT: tgt_h_q <= cfg_data_i;
      endcase
    end
  end

  assign sw     = eff_dim(src_w_q);
  assign sh     = eff_dim(src_h_q);
  assign tw_raw = eff_dim(tgt_w_q);
  assign th_raw = eff_dim(tgt_h_q);
  assign tw     = (tw_raw > sw) ? sw : tw_raw;
  assign th     = (th_raw > sh) ? sh : th_raw;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      red_q   <= red_in_i;
      green_q <= green_in_i;
      blue_q  <= blue_in_i;
      fs_q    <= frame_start_i;
    end
  end

  // frame start clears everything before the pixel is looked at
  assign sc = fs_q ? '0 : sc_q;
  assign sr = fs_q ? '0 : sr_q;
  assign wc = fs_q ? '0 : wc_q;
  assign wr = fs_q ? '0 : wr_q;
  assign dc = fs_q ? '0 : dc_q;
  assign dr = fs_q ? '0 : dr_q;

  assign hit      = (dr < th) && (dc < tw) && (sr == wr) && (sc == wc);
  assign dc1      = dc + CntW'(hit);
  assign sc1      = DimW'(sc) + DimW'(1);
  assign row_end  = sc1 >= sw;
  assign row_used = (sr == wr) && (dr < th);
  assign sr1      = DimW'(sr) + DimW'(1);
  assign dr1      = dr + CntW'(row_used);
  assign row_wrap = sr1 >= sh;
  // at a row end the column position is forced to zero, so no column divide
  assign col_div  = hit && (dc1 < tw) && !row_end;
  assign row_div  = row_end && row_used && (dr1 < th) && !row_wrap;

  always_comb begin
    sc_d = sc_q;
    sr_d = sr_q;
    wc_d = wc_q;
    wr_d = wr_q;
    dc_d = dc_q;
    dr_d = dr_q;
    if (cmd_i.step) begin
      if (row_end) begin
        sc_d = '0;
        dc_d = '0;
        wc_d = '0;
        if (row_wrap) begin
          sr_d = '0;
          dr_d = '0;
          wr_d = '0;
        end else begin
          sr_d = sr1[CoordW-1:0];
          dr_d = dr1;
          wr_d = wr;
        end
      end else begin
        sc_d = sc1[CoordW-1:0];
        dc_d = dc1;
        wc_d = wc;
        sr_d = sr;
        dr_d = dr;
        wr_d = wr;
      end
    end else if (cmd_i.wb) begin
      if (div_row_q) begin
        wr_d = div_quo;
      end else begin
        wc_d = div_quo;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q <= '0;
      sr_q <= '0;
      wc_q <= '0;
      wr_q <= '0;
      dc_q <= '0;
      dr_q <= '0;
    end else begin
      sc_q <= sc_d;
      sr_q <= sr_d;
      wc_q <= wc_d;
      wr_q <= wr_d;
      dc_q <= dc_d;
      dr_q <= dr_d;
    end
  end

  // next sample position = floor(d * src / dst)
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      div_row_q <= row_div;
      div_d_q   <= row_div ? dr1 : dc1;
      div_src_q <= row_div ? sh : sw;
      div_dst_q <= row_div ? th : tw;
    end
  end

  assign prod = ProdW'(div_d_q) * ProdW'(div_src_q);

  ndd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod),
    .divisor_i  (div_dst_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // output register
  assign out_busy = out_valid_q && out_stall_i;
  assign out_load = cmd_i.step && hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_load || out_busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_red_q   <= red_q;
      out_green_q <= green_q;
      out_blue_q  <= blue_q;
      out_col_q   <= dc[CoordW-1:0];
      out_row_q   <= dr[CoordW-1:0];
      out_fe_q    <= (dc == tw - DimW'(1)) && (dr == th - DimW'(1));
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_out_o    = out_red_q;
  assign green_out_o  = out_green_q;
  assign blue_out_o   = out_blue_q;
  assign out_column_o = out_col_q;
  assign out_row_o    = out_row_q;
  assign frame_end_o  = out_fe_q;

  assign sts_o.hit      = hit;
  assign sts_o.out_busy = out_busy;
  assign sts_o.need_div = col_div || row_div;
  assign sts_o.div_done = div_done;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> !(hit && out_busy))
    else $error("pixel emitted over a stalled result");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> !div_busy)
    else $error("divider restarted while running");

  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wb |-> (DimW'(div_quo) < div_src_q))
    else $error("sample position outside source frame");

  a_frame_end_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_fe_q) |-> (CntW'(out_col_q) == tw - DimW'(1)))
    else $error("frame end flagged off the last column");

endmodule

>>> rtl/ndd_ctrl.sv
// Controller FSM: accepts a pixel, steps the datapath, sequences the divide.
// Depends on ndd_pkg; talks to ndd_dp only through dp_cmd_t / dp_sts_t.
module ndd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ndd_pkg::dp_sts_t sts_i,
  output ndd_pkg::dp_cmd_t cmd_o
);
  import ndd_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_STEP;
        end
      end
      ST_STEP: begin
        // a sampled pixel waits until the output register can take it
        if (!(sts_i.hit && sts_i.out_busy)) begin
          cmd_o.step = 1'b1;
          state_d    = sts_i.need_div ? ST_DIV_START : ST_IDLE;
        end
      end
      ST_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.wb = 1'b1;
          state_d  = ST_IDLE;
        end
      end
    endcase
  end

endmodule

>>> tb/ndd_checker.sv
// Scoreboard for the nearest-neighbor downscaler: watches pixel, result and register beats.
// Predicts the sampled pixels from its own copy of the size registers and position counters.
// Depends on ndd_pkg for widths and the register index enum.
`timescale 1ns / 1ps

module ndd_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [ndd_pkg::ColorW-1:0]  red_in_i,
  input  logic [ndd_pkg::ColorW-1:0]  green_in_i,
  input  logic [ndd_pkg::ColorW-1:0]  blue_in_i,
  input  logic                        frame_start_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [ndd_pkg::ColorW-1:0]  red_out_i,
  input  logic [ndd_pkg::ColorW-1:0]  green_out_i,
  input  logic [ndd_pkg::ColorW-1:0]  blue_out_i,
  input  logic [ndd_pkg::CoordW-1:0]  out_column_i,
  input  logic [ndd_pkg::CoordW-1:0]  out_row_i,
  input  logic                        frame_end_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  ndd_pkg::cfg_reg_e           cfg_index_i,
  input  logic [ndd_pkg::DimW-1:0]    cfg_data_i,
  output int                          mismatches_o,
  output int                          pending_o
);
  import ndd_pkg::*;

  typedef struct packed {
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
    logic [CoordW-1:0] column;
    logic [CoordW-1:0] row;
    logic              last;
  } pixel_beat_t;

  pixel_beat_t sampled_q[$];
  int          mismatches;

  logic [DimW-1:0] reg_src_w, reg_src_h, reg_tgt_w, reg_tgt_h;
  // Counters are one bit wider than a coordinate so they can reach MaxDim.
  logic [7:0]      src_col, src_row, dst_col, dst_row, want_col, want_row;

  function automatic logic [7:0] clamp_dim(input logic [DimW-1:0] v);
    if (v == 0) return 8'd1;
    if (v > MaxDim) return 8'(MaxDim);
    return v;
  endfunction

  // Source index sampled by destination index d: floor(d * src / dst), kept below src.
  function automatic logic [7:0] sample_point(input logic [7:0] d, src, dst);
    logic [15:0] q;
    q = (16'(d) * 16'(src)) / 16'(dst);
    if (q >= 16'(src)) q = 16'(src) - 16'd1;
    return q[7:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic [7:0]  sw, sh, tw, th;
    logic        row_used;
    pixel_beat_t got, want;
    if (!rst_ni) begin
      sampled_q.delete();
      mismatches = 0;
      reg_src_w  = ResetDim;
      reg_src_h  = ResetDim;
      reg_tgt_w  = ResetDim;
      reg_tgt_h  = ResetDim;
      src_col    = '0;
      src_row    = '0;
      dst_col    = '0;
      dst_row    = '0;
      want_col   = '0;
      want_row   = '0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      // Result beat: compare against the oldest prediction.
      if (out_valid_i && !out_stall_i) begin
        got = '{red: red_out_i, green: green_out_i, blue: blue_out_i,
                column: out_column_i, row: out_row_i, last: frame_end_i};
        if (sampled_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ndd_checker: unexpected beat rgb=%02h%02h%02h col=%0d row=%0d end=%0b",
                     got.red, got.green, got.blue, got.column, got.row, got.last);
        end else begin
          want = sampled_q.pop_front();
          if (got.red != want.red || got.green != want.green || got.blue != want.blue ||
              got.column != want.column || got.row != want.row || got.last != want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("ndd_checker: mismatch exp rgb=%02h%02h%02h col=%0d row=%0d end=%0b",
                     want.red, want.green, want.blue, want.column, want.row, want.last);
              $display(" got rgb=%02h%02h%02h col=%0d row=%0d end=%0b",
                       got.red, got.green, got.blue, got.column, got.row, got.last);
            end
          end
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SRC_WIDTH:  reg_src_w = cfg_data_i;
          CFG_SRC_HEIGHT: reg_src_h = cfg_data_i;
          CFG_TGT_WIDTH:  reg_tgt_w = cfg_data_i;
          CFG_TGT_HEIGHT: reg_tgt_h = cfg_data_i;
          default: ;
        endcase
      end

      // Pixel beat: step the position counters, queue the pixel if it is a sample point.
      if (in_valid_i && !in_stall_i) begin
        sw = clamp_dim(reg_src_w);
        sh = clamp_dim(reg_src_h);
        tw = clamp_dim(reg_tgt_w);
        th = clamp_dim(reg_tgt_h);
        if (tw > sw) tw = sw;
        if (th > sh) th = sh;
        if (frame_start_i) begin
          src_col  = '0;
          src_row  = '0;
          dst_col  = '0;
          dst_row  = '0;
          want_col = '0;
          want_row = '0;
        end
        if (dst_row < th && dst_col < tw && src_row == want_row && src_col == want_col) begin
          sampled_q.push_back('{red: red_in_i, green: green_in_i, blue: blue_in_i,
                                column: dst_col[CoordW-1:0], row: dst_row[CoordW-1:0],
                                last: (dst_col == tw - 8'd1 && dst_row == th - 8'd1)});
          dst_col++;
          if (dst_col < tw) want_col = sample_point(dst_col, sw, tw);
        end
        src_col++;
        if (src_col >= sw) begin
          row_used = (src_row == want_row) && (dst_row < th);
          src_col  = '0;
          dst_col  = '0;
          want_col = '0;
          src_row++;
          if (row_used) begin
            dst_row++;
            if (dst_row < th) want_row = sample_point(dst_row, sh, th);
          end
          if (src_row >= sh) begin
            src_row  = '0;
            dst_row  = '0;
            want_row = '0;
          end
        end
      end

      mismatches_o <= mismatches;
      pending_o    <= sampled_q.size();
    end
  end

endmodule

>>> tb/tb_top.sv
// Testbench top for the nearest-neighbor downscaler: clock, reset, stimulus and verdict.
// Depends on ndd_pkg, nearest_neighbour_downscaler_top and ndd_checker.
`timescale 1ns / 1ps

module tb_top;
  import ndd_pkg::*;

  // Cycles without any beat on any channel before the run is declared hung. The slowest
  // pixel waits out a full divide, stall runs are short, and the longest quiet stretch we create
  // ourselves is the settle hold-off.
  localparam int WatchLimit = 2000;
  localparam int HoldOff    = 24;
  localparam int ItemTarget = 700;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // pixel source side
  logic              in_valid    = 1'b0;
  logic              in_stall;
  logic [ColorW-1:0] red_in      = '0;
  logic [ColorW-1:0] green_in    = '0;
  logic [ColorW-1:0] blue_in     = '0;
  logic              frame_start = 1'b0;

  // result sink side
  logic              out_valid;
  logic              out_stall   = 1'b0;
  logic [ColorW-1:0] red_out, green_out, blue_out;
  logic [CoordW-1:0] out_column, out_row;
  logic              frame_end;

  // register write channel
  logic              cfg_valid   = 1'b0;
  logic              cfg_ready;
  cfg_reg_e          cfg_index   = CFG_SRC_WIDTH;
  logic [DimW-1:0]   cfg_data    = '0;

  int mismatches;
  int pending;
  int items_sent    = 0;
  int rcv_stall_pct = 52;
  int quiet_cycles  = 0;

  always #4 clk_i = ~clk_i;

  nearest_neighbour_downscaler_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .red_in_i      (red_in),
    .green_in_i    (green_in),
    .blue_in_i     (blue_in),
    .frame_start_i (frame_start),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .red_out_o     (red_out),
    .green_out_o   (green_out),
    .blue_out_o    (blue_out),
    .out_column_o  (out_column),
    .out_row_o     (out_row),
    .frame_end_o   (frame_end),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  ndd_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .red_in_i      (red_in),
    .green_in_i    (green_in),
    .blue_in_i     (blue_in),
    .frame_start_i (frame_start),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .red_out_i     (red_out),
    .green_out_i   (green_out),
    .blue_out_i    (blue_out),
    .out_column_i  (out_column),
    .out_row_i     (out_row),
    .frame_end_i   (frame_end),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  // Result sink: random stall, rate set by the current idling regime.
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
  end

  // Hang detection: any accepted beat on any channel restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WatchLimit) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // Zero reads as one, anything above MaxDim as MaxDim; used only to size frames.
  function automatic int dim_of(input logic [DimW-1:0] v);
    if (v == 0) return 1;
    if (v > MaxDim) return MaxDim;
    return int'(v);
  endfunction

  // One pixel beat. Idling regime follows the item count: sender idles 19% / sink
  // stalls 52% first, then swapped, then neither. Idle cycles are decided before valid
  // goes up, so valid is never dropped and raised in the same step.
  task automatic send_pixel(input logic [ColorW-1:0] r, g, b, input logic fs);
    int idle_pct;
    idle_pct = (items_sent < 233) ? 19 : (items_sent < 466) ? 52 : 0;
    rcv_stall_pct <= (items_sent < 233) ? 52 : (items_sent < 466) ? 19 : 0;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    red_in      <= r;
    green_in    <= g;
    blue_in     <= b;
    frame_start <= fs;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    items_sent++;
  endtask

  // Stop sending, wait for every predicted result, then let a pixel that makes no
  // result finish its step (divide included) before anything else happens.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (HoldOff) @(posedge clk_i);
  endtask

  // All four size registers, valid held high across the back-to-back beats.
  task automatic write_config(input logic [DimW-1:0] sw, sh, tw, th);
    cfg_reg_e        idx[4];
    logic [DimW-1:0] val[4];
    idx = '{CFG_SRC_WIDTH, CFG_SRC_HEIGHT, CFG_TGT_WIDTH, CFG_TGT_HEIGHT};
    val = '{sw, sh, tw, th};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk_i);
      while (!cfg_ready) @(posedge clk_i);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int              phase;
    int              mode;
    int              n_pix;
    int              n_frames;
    int              len;
    bit              broken;
    bit              lead;
    logic [DimW-1:0] sw, sh, tw, th;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset sizes (96 -> 96, every pixel passes), color extremes.
    send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'hA5, 8'h5A, 8'h3C, 1'b0);
    settle();

    // 4x3 down to 2x2: a full frame, last pixel marked.
    write_config(8'd4, 8'd3, 8'd2, 8'd2);
    for (int i = 0; i < 12; i++)
      send_pixel((i % 2) ? 8'hFF : 8'h00, (i % 3) ? 8'h7F : 8'h80, 8'(i * 21), i == 0);
    settle();

    // Zero sizes read as one, 255 as 128 then clamped to the source: 1x1 frames that
    // wrap on their own without frame_start.
    write_config(8'd0, 8'd0, 8'd255, 8'd0);
    send_pixel(8'h12, 8'h34, 8'h56, 1'b1);
    send_pixel(8'hFE, 8'h01, 8'h80, 1'b0);
    send_pixel(8'h01, 8'hFE, 8'h7F, 1'b0);
    settle();

    // Target above source: clamped, so the 3x2 frame passes through whole.
    write_config(8'd3, 8'd2, 8'd5, 8'd9);
    for (int i = 0; i < 6; i++)
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom), i == 0);

    // Random phases: mostly small frames, every third phase one of the extreme shapes.
    phase = 0;
    while (items_sent < ItemTarget) begin
      settle();
      mode = (phase % 3 == 1) ? (phase / 3) % 4 + 1 : 0;
      case (mode)
        1: begin  // full 128-pixel row, any target width
          sw = 8'd128;
          sh = 8'd1;
          tw = 8'($urandom_range(1, 128));
          th = 8'd1;
        end
        2: begin  // oversized source width, zero target width
          sw = 8'd255;
          sh = 8'd1;
          tw = 8'd0;
          th = 8'($urandom_range(0, 255));
        end
        3: begin  // one column, 128 rows
          sw = 8'd1;
          sh = 8'd200;
          tw = 8'd1;
          th = 8'($urandom_range(1, 128));
        end
        4: begin  // medium frame with target at least as wide as source
          sw = 8'($urandom_range(9, 16));
          sh = 8'($urandom_range(9, 16));
          tw = sw + 8'($urandom_range(0, 8));
          th = sh;
        end
        default: begin
          sw = 8'($urandom_range(1, 8));
          sh = 8'($urandom_range(1, 8));
          tw = 8'($urandom_range(1, sw + 2));
          th = 8'($urandom_range(1, sh + 2));
          if ($urandom_range(0, 7) == 0) tw = 8'd0;
          if ($urandom_range(0, 7) == 0) th = 8'd0;
        end
      endcase
      write_config(sw, sh, tw, th);
      n_pix    = dim_of(sw) * dim_of(sh);
      n_frames = (mode == 0) ? $urandom_range(1, 3) : 1;
      for (int f = 0; f < n_frames; f++) begin
        // Broken frames: wrong length, missing or stray frame_start.
        broken = (mode == 0) && ($urandom_range(0, 4) == 0);
        len    = broken ? $urandom_range(1, 2 * n_pix + 3) : n_pix;
        lead   = broken ? 1'($urandom_range(0, 1)) : 1'b1;
        for (int i = 0; i < len; i++)
          send_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                     (i == 0 && lead) || (broken && $urandom_range(0, 15) == 0));
        // Now and then drain the block completely between frames.
        if ($urandom_range(0, 3) == 0) settle();
      end
      phase++;
    end

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
